// File: rtl/vpm_pkg.sv
// ----------------------------------------------------------------------------
// vpm_pkg
// Shared types and constants for the volume profile and MIP accumulator.
// ----------------------------------------------------------------------------
package vpm_pkg;

  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int SIZE_W      = 13;
  localparam int SIZE_RESET  = 1024;
  localparam int ADDR_W      = 12;
  localparam int IDX_W       = 10;
  localparam int VOX_W       = 16;
  localparam int SUM_W       = 36;
  localparam int KIND_W      = 2;
  localparam int AXIS_W      = 2;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 72;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_VOXEL = 2'd0,
    KIND_START = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_ROW   = 2'd0,
    AXIS_COL   = 2'd1,
    AXIS_SLICE = 2'd2
  } axis_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_SLICES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [VOX_W-1:0] maxv;
  } entry_t;

  // one queued operation: a voxel update or an entry read
  typedef struct packed {
    logic              is_read;
    logic [VOX_W-1:0]  voxel;
    logic [ADDR_W-1:0] row_addr;
    logic [ADDR_W-1:0] col_addr;
    logic [ADDR_W-1:0] slice_addr;
    logic              row_first;
    logic              col_first;
    logic              slice_first;
    axis_t             axis;
    logic              written;
    logic              oor;
    logic [VOX_W-1:0]  peak;
    logic              done;
  } q_item_t;

endpackage

// File: rtl/vpm_lane.sv
// ----------------------------------------------------------------------------
// vpm_lane
// Sum and maximum store for one axis, with read-modify-write and bypass.
// ----------------------------------------------------------------------------
module vpm_lane #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [vpm_pkg::ADDR_W-1:0] rd_addr,
  input  logic                     upd_en,
  input  logic [vpm_pkg::ADDR_W-1:0] upd_addr,
  input  logic                     upd_first,
  input  logic [vpm_pkg::VOX_W-1:0]  upd_voxel,
  output vpm_pkg::entry_t          cur
);
  import vpm_pkg::*;

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_EXT_W = SUM_W + 1;

  entry_t          mem [DEPTH];
  entry_t          rdata;
  entry_t          lw_data;
  logic [AW-1:0]   lw_addr;
  entry_t          upd_value;
  logic [SUM_EXT_W-1:0] sum_ext;

  // last write bypasses the read that raced it
  assign cur     = (AW'(upd_addr) == lw_addr) ? lw_data : rdata;
  assign sum_ext = {1'b0, cur.sum} + SUM_EXT_W'(upd_voxel);

  always_comb begin
    if (upd_first) begin
      upd_value.sum  = SUM_W'(upd_voxel);
      upd_value.maxv = upd_voxel;
    end else begin
      upd_value.sum  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      upd_value.maxv = (upd_voxel > cur.maxv) ? upd_voxel : cur.maxv;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[AW'(rd_addr)];
    end
    if (upd_en) begin
      mem[AW'(upd_addr)] <= upd_value;
      lw_addr            <= AW'(upd_addr);
      lw_data            <= upd_value;
    end
  end

endmodule

// File: rtl/vpm_queue.sv
// ----------------------------------------------------------------------------
// vpm_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module vpm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vpm_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output vpm_pkg::q_item_t pop_item
);
  import vpm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_item_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/vpm_front.sv
// ----------------------------------------------------------------------------
// vpm_front
// Accepts items, keeps sizes, raster position, fill counts and the peak,
// and queues voxel updates and entry reads for the back.
// ----------------------------------------------------------------------------
module vpm_front #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_SLICES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [vpm_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [vpm_pkg::KIND_W-1:0]    s_tuser,
  input  logic                          q_full,
  output logic                          push,
  output vpm_pkg::q_item_t              push_item
);
  import vpm_pkg::*;

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SAW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int SCW = $clog2(MAX_SLICES + 1);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] w;
    w = SIZE_W'(v);
    if (w == '0) return SIZE_W'(1);
    if (w > limit) return limit;
    return w;
  endfunction

  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  logic [CFG_W-1:0] slices_cfg;
  logic [RAW-1:0]   row_pos;
  logic [CAW-1:0]   col_pos;
  logic [SAW-1:0]   slice_pos;
  logic [RCW-1:0]   row_fill;
  logic [CCW-1:0]   col_fill;
  logic [SCW-1:0]   slice_fill;
  logic [VOX_W-1:0] peak;
  logic             done;

  logic             accept;
  kind_t            kind;
  axis_t            axis;
  logic [VOX_W-1:0] voxel;
  logic [IDX_W-1:0] idx;
  logic [SIZE_W-1:0] idx_w;
  logic [RCW-1:0]   nr;
  logic [CCW-1:0]   nc;
  logic [SCW-1:0]   ns;
  logic [RCW-1:0]   row_inc;
  logic [CCW-1:0]   col_inc;
  logic [SCW-1:0]   slice_inc;
  logic             row_first;
  logic             col_first;
  logic             slice_first;
  logic             in_rng;
  logic             wr_seen;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  assign kind  = kind_t'(s_tuser);
  assign voxel = s_tdata[VOX_W-1:0];
  assign axis  = axis_t'(s_tdata[VOX_W +: AXIS_W]);
  assign idx   = s_tdata[VOX_W + AXIS_W +: IDX_W];
  assign idx_w = SIZE_W'(idx);

  assign nr = RCW'(clamp_size(rows_cfg, SIZE_W'(MAX_ROWS)));
  assign nc = CCW'(clamp_size(cols_cfg, SIZE_W'(MAX_COLS)));
  assign ns = SCW'(clamp_size(slices_cfg, SIZE_W'(MAX_SLICES)));

  assign row_inc   = RCW'(row_pos) + RCW'(1);
  assign col_inc   = CCW'(col_pos) + CCW'(1);
  assign slice_inc = SCW'(slice_pos) + SCW'(1);

  // positions count up from zero and wrap back to zero, so written entries form a prefix
  assign row_first   = (RCW'(row_pos) == row_fill);
  assign col_first   = (CCW'(col_pos) == col_fill);
  assign slice_first = (SCW'(slice_pos) == slice_fill);

  always_comb begin
    case (axis)
      AXIS_ROW: begin
        in_rng  = idx_w < SIZE_W'(nr);
        wr_seen = idx_w < SIZE_W'(row_fill);
      end
      AXIS_COL: begin
        in_rng  = idx_w < SIZE_W'(nc);
        wr_seen = idx_w < SIZE_W'(col_fill);
      end
      AXIS_SLICE: begin
        in_rng  = idx_w < SIZE_W'(ns);
        wr_seen = idx_w < SIZE_W'(slice_fill);
      end
      default: begin
        in_rng  = 1'b0;
        wr_seen = 1'b0;
      end
    endcase
  end

  always_comb begin
    push_item.is_read     = (kind == KIND_READ);
    push_item.voxel       = voxel;
    push_item.row_first   = row_first;
    push_item.col_first   = col_first;
    push_item.slice_first = slice_first;
    push_item.axis        = axis;
    push_item.written     = in_rng && wr_seen;
    push_item.oor         = !in_rng;
    push_item.peak        = peak;
    push_item.done        = done;
    if (kind == KIND_READ) begin
      push_item.row_addr   = ADDR_W'(idx);
      push_item.col_addr   = ADDR_W'(idx);
      push_item.slice_addr = ADDR_W'(idx);
    end else begin
      push_item.row_addr   = ADDR_W'(row_pos);
      push_item.col_addr   = ADDR_W'(col_pos);
      push_item.slice_addr = ADDR_W'(slice_pos);
    end
    push = accept && (((kind == KIND_VOXEL) && !done) || (kind == KIND_READ));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg   <= CFG_W'(SIZE_RESET);
      cols_cfg   <= CFG_W'(SIZE_RESET);
      slices_cfg <= CFG_W'(SIZE_RESET);
      row_pos    <= '0;
      col_pos    <= '0;
      slice_pos  <= '0;
      row_fill   <= '0;
      col_fill   <= '0;
      slice_fill <= '0;
      peak       <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROWS:   rows_cfg   <= cfg_data;
          REG_COLS:   cols_cfg   <= cfg_data;
          REG_SLICES: slices_cfg <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        case (kind)
          KIND_START: begin
            row_pos    <= '0;
            col_pos    <= '0;
            slice_pos  <= '0;
            row_fill   <= '0;
            col_fill   <= '0;
            slice_fill <= '0;
            peak       <= '0;
            done       <= 1'b0;
          end
          KIND_VOXEL: begin
            if (!done) begin
              if (voxel > peak) begin
                peak <= voxel;
              end
              if (row_first) begin
                row_fill <= row_fill + RCW'(1);
              end
              if (col_first) begin
                col_fill <= col_fill + CCW'(1);
              end
              if (slice_first) begin
                slice_fill <= slice_fill + SCW'(1);
              end
              if (col_inc >= nc) begin
                col_pos <= '0;
                if (row_inc >= nr) begin
                  row_pos <= '0;
                  if (slice_inc >= ns) begin
                    slice_pos <= '0;
                    done      <= 1'b1;
                  end else begin
                    slice_pos <= SAW'(slice_inc);
                  end
                end else begin
                  row_pos <= RAW'(row_inc);
                end
              end else begin
                col_pos <= CAW'(col_inc);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/vpm_back.sv
// ----------------------------------------------------------------------------
// vpm_back
// Drains the queue: updates the three axis stores and answers entry reads
// through the output register.
// ----------------------------------------------------------------------------
module vpm_back #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_SLICES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  vpm_pkg::q_item_t              q_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vpm_pkg::M_TDATA_W-1:0] m_tdata
);
  import vpm_pkg::*;

  logic    b_valid;
  q_item_t b_item;
  logic    out_free;
  logic    b_go;
  logic    b_free;
  logic    upd_en;
  logic    out_load;
  entry_t  row_cur;
  entry_t  col_cur;
  entry_t  slice_cur;
  entry_t  sel;
  entry_t  res;

  assign out_free = !m_tvalid || m_tready;
  assign b_go     = b_valid && (!b_item.is_read || out_free);
  assign b_free   = !b_valid || b_go;
  assign pop      = q_valid && b_free;
  assign upd_en   = b_valid && !b_item.is_read;
  assign out_load = b_valid && b_item.is_read && out_free;

  vpm_lane #(.DEPTH(MAX_ROWS)) u_row (
    .clk       (clk),
    .rd_en     (pop),
    .rd_addr   (q_item.row_addr),
    .upd_en    (upd_en),
    .upd_addr  (b_item.row_addr),
    .upd_first (b_item.row_first),
    .upd_voxel (b_item.voxel),
    .cur       (row_cur)
  );

  vpm_lane #(.DEPTH(MAX_COLS)) u_col (
    .clk       (clk),
    .rd_en     (pop),
    .rd_addr   (q_item.col_addr),
    .upd_en    (upd_en),
    .upd_addr  (b_item.col_addr),
    .upd_first (b_item.col_first),
    .upd_voxel (b_item.voxel),
    .cur       (col_cur)
  );

  vpm_lane #(.DEPTH(MAX_SLICES)) u_slice (
    .clk       (clk),
    .rd_en     (pop),
    .rd_addr   (q_item.slice_addr),
    .upd_en    (upd_en),
    .upd_addr  (b_item.slice_addr),
    .upd_first (b_item.slice_first),
    .upd_voxel (b_item.voxel),
    .cur       (slice_cur)
  );

  always_comb begin
    case (b_item.axis)
      AXIS_ROW:   sel = row_cur;
      AXIS_COL:   sel = col_cur;
      AXIS_SLICE: sel = slice_cur;
      default:    sel = '0;
    endcase
    // unwritten or out-of-range entries read as zero
    res = (b_item.written && !b_item.oor) ? sel : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, b_item.done, b_item.oor, b_item.peak, res.maxv, res.sum};
    end
  end

endmodule

// File: rtl/volume_profile_and_mip_accumulator.sv
// ----------------------------------------------------------------------------
// volume_profile_and_mip_accumulator
// Row, column and slice sums and maxima of a raster-ordered voxel volume.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the queue is full or a read waits
// on m_tready; each voxel does one read-modify-write per axis store with a
// one-deep write bypass for back-to-back hits. A read result reaches
// m_tvalid through the queue slot, the store read and the output register.
// Reset clears positions, fill counts, peak and flags; sizes return to 1024.
// Stores need no clearing pass: fill counts mark entries written this volume.
module volume_profile_and_mip_accumulator #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int MAX_SLICES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // voxel[15:0], axis[17:16], index[27:18], zero[31:28]
  input  logic [vpm_pkg::S_TDATA_W-1:0] s_tdata,
  // kind[1:0]
  input  logic [vpm_pkg::KIND_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // profile_sum[35:0], projection_max[51:36], overall_max[67:52],
  // out_of_range[68], volume_done[69], zero[71:70]
  output logic [vpm_pkg::M_TDATA_W-1:0] m_tdata
);
  import vpm_pkg::*;

  logic    q_full;
  logic    push;
  q_item_t push_item;
  logic    pop;
  logic    q_valid;
  q_item_t q_item;

  vpm_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_SLICES (MAX_SLICES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  vpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  vpm_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_SLICES (MAX_SLICES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
